>>> src/spf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_pkg
// Shared sizes and the table port bundle for the smallest-prime-factor
// sieve factorizer.
// ----------------------------------------------------------------------------
package spf_pkg;

    localparam int TABLE_SIZE = 65536;
    localparam int ADDR_W     = $clog2(TABLE_SIZE);
    localparam int VAL_W      = 16;
    localparam int ENTRY_W    = 16;
    // sieve index: wide enough for sqrt(TABLE_SIZE) plus one odd step
    localparam int SQ_W       = ADDR_W / 2 + 2;
    localparam int MAX_OUT    = 15;
    localparam int CNT_W      = $clog2(MAX_OUT + 1);
    localparam int DIV_CNT_W  = $clog2(VAL_W);

    typedef struct packed {
        logic                we;
        logic [ADDR_W-1:0]   waddr;
        logic [ENTRY_W-1:0]  wdata;
        logic [ADDR_W-1:0]   raddr;
    } t_tbl_req;

endpackage

>>> src/spf_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_table
// Single-port-write, single-port-read factor table with registered read data.
// ----------------------------------------------------------------------------
module spf_table
    import spf_pkg::*;
(
    input  logic                i_clk,
    input  t_tbl_req            i_req,
    output logic [ENTRY_W-1:0]  o_rdata
);

    logic [ENTRY_W-1:0] r_mem [TABLE_SIZE];
    logic [ENTRY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/spf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module spf_div
    import spf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [VAL_W-1:0]  i_dividend,
    input  logic [VAL_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [VAL_W-1:0]  o_quotient
);

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [VAL_W-1:0]      r_rem;
    logic [VAL_W-1:0]      r_quo;
    logic [VAL_W-1:0]      r_dvs;

    logic [VAL_W:0]        w_shift;
    logic [VAL_W:0]        w_diff;

    assign w_shift = {r_rem, r_quo[VAL_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                if (!w_diff[VAL_W]) begin
                    r_rem <= w_diff[VAL_W-1:0];
                    r_quo <= {r_quo[VAL_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_shift[VAL_W-1:0];
                    r_quo <= {r_quo[VAL_W-2:0], 1'b0};
                end
                if (r_cnt == DIV_CNT_W'(VAL_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_cnt  <= '0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy) else $error("divider restarted while busy");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_busy)) else $error("done without a division");
    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_cnt == '0)) else $error("step count left over");
`endif

endmodule

>>> src/spf_sieve_factorizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_sieve_factorizer_top
// Builds a smallest-prime-factor table after reset, then factorizes each
// input value by table lookup and division, one prime factor per output beat.
//
//   channel | signals                       | beat
//   --------+-------------------------------+-----------------------------
//   in      | i_valid o_stall i_value       | one value to factorize
//   out     | o_valid i_stall o_factor      | one prime factor, ascending,
//           |         o_last                | o_last on the final one
//
// After reset the table is built: a fill pass over all TABLE_SIZE entries, then
// a sieve pass that reads and may rewrite each visited entry; o_stall is high
// throughout. Per value, each factor takes a table lookup, a divider start,
// the division and an output beat, plus any output stall; a value below 2
// is taken with no output beat.
// o_stall goes high once a value of 2 or more is taken and stays high until its
// last factor beat is taken; a stalled output beat holds.
// ----------------------------------------------------------------------------
module spf_sieve_factorizer_top
    import spf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [VAL_W-1:0]  i_value,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [VAL_W-1:0]  o_factor,
    output logic              o_last
);

    typedef enum logic [3:0] {
        S_FILL,
        S_SV_SQ,
        S_SV_TEST,
        S_SV_CHK_I,
        S_SV_RD_J,
        S_SV_WR_J,
        S_IDLE,
        S_LOOK,
        S_DIVGO,
        S_DIVW,
        S_EMIT
    } t_state;

    localparam logic [2*SQ_W-1:0] SQ_LIMIT = (2*SQ_W)'(TABLE_SIZE - 1);

    t_state                r_state;
    logic [ADDR_W-1:0]     r_fill;
    logic [SQ_W-1:0]       r_i;
    logic [2*SQ_W-1:0]     r_sq;
    logic [ADDR_W:0]       r_j;
    logic [VAL_W-1:0]      r_rem;
    logic [ENTRY_W-1:0]    r_p;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_valid;
    logic [VAL_W-1:0]      r_factor;
    logic                  r_last;

    t_tbl_req              w_req;
    logic [ENTRY_W-1:0]    w_rdata;
    logic                  w_div_start;
    logic                  w_div_done;
    logic [VAL_W-1:0]      w_quo;
    logic [ADDR_W:0]       n_j;
    logic                  w_in_ok;

    spf_table u_table (
        .i_clk   (i_clk),
        .i_req   (w_req),
        .o_rdata (w_rdata)
    );

    spf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_rem),
        .i_divisor  (VAL_W'(w_rdata)),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign n_j     = r_j + (ADDR_W+1)'(r_i);
    assign w_in_ok = (i_value > VAL_W'(1)) && (32'(i_value) < 32'(TABLE_SIZE));
    assign w_div_start = (r_state == S_DIVGO) && (w_rdata > ENTRY_W'(1));

    always_comb begin
        w_req = '0;
        case (r_state)
            S_FILL: begin
                w_req.we    = 1'b1;
                w_req.waddr = r_fill;
                // even entries above zero start as 2, the rest as their index
                w_req.wdata = (!r_fill[0] && (r_fill != '0)) ? ENTRY_W'(2)
                                                             : ENTRY_W'(r_fill);
            end
            S_SV_TEST: begin
                w_req.raddr = ADDR_W'(r_i);
            end
            S_SV_RD_J: begin
                w_req.raddr = r_j[ADDR_W-1:0];
            end
            S_SV_WR_J: begin
                w_req.we    = (w_rdata == ENTRY_W'(r_j[ADDR_W-1:0]));
                w_req.waddr = r_j[ADDR_W-1:0];
                w_req.wdata = ENTRY_W'(r_i);
            end
            S_LOOK: begin
                w_req.raddr = ADDR_W'(r_rem);
            end
            default: begin
                w_req = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FILL;
            r_fill  <= '0;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            case (r_state)
                S_FILL: begin
                    r_fill <= r_fill + 1'b1;
                    if (r_fill == '1) begin
                        r_i     <= SQ_W'(3);
                        r_state <= S_SV_SQ;
                    end
                end
                S_SV_SQ: begin
                    r_sq    <= r_i * r_i;
                    r_state <= S_SV_TEST;
                end
                S_SV_TEST: begin
                    r_state <= (r_sq > SQ_LIMIT) ? S_IDLE : S_SV_CHK_I;
                end
                S_SV_CHK_I: begin
                    if (w_rdata == ENTRY_W'(r_i)) begin
                        r_j     <= (ADDR_W+1)'(r_sq);
                        r_state <= S_SV_RD_J;
                    end else begin
                        r_i     <= r_i + SQ_W'(2);
                        r_state <= S_SV_SQ;
                    end
                end
                S_SV_RD_J: begin
                    r_state <= S_SV_WR_J;
                end
                S_SV_WR_J: begin
                    r_j <= n_j;
                    if (n_j[ADDR_W]) begin
                        r_i     <= r_i + SQ_W'(2);
                        r_state <= S_SV_SQ;
                    end else begin
                        r_state <= S_SV_RD_J;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_rem <= i_value;
                        r_cnt <= '0;
                        if (w_in_ok) begin
                            r_state <= S_LOOK;
                        end
                    end
                end
                S_LOOK: begin
                    r_state <= S_DIVGO;
                end
                S_DIVGO: begin
                    r_p     <= w_rdata;
                    r_state <= w_div_start ? S_DIVW : S_IDLE;
                end
                S_DIVW: begin
                    if (w_div_done) begin
                        r_rem    <= w_quo;
                        r_valid  <= 1'b1;
                        r_factor <= VAL_W'(r_p);
                        r_last   <= (w_quo <= VAL_W'(1)) ||
                                    (r_cnt == CNT_W'(MAX_OUT - 1));
                        r_cnt    <= r_cnt + 1'b1;
                        r_state  <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!i_stall) begin
                        r_valid <= 1'b0;
                        r_state <= r_last ? S_IDLE : S_LOOK;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_factor = r_factor;
    assign o_last   = r_last;

`ifndef SYNTHESIS
    a_factor_prime_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_factor >= VAL_W'(2))) else $error("factor below two");
    a_no_take_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall |-> !o_valid) else $error("input open with a beat pending");
    a_beat_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_cnt != '0)) else $error("output beat not counted");
    a_next_factor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last) |=> (r_state == S_LOOK))
        else $error("factor loop did not continue");
`endif

endmodule
